/* src/csbc_pkg.sv */
// shared types, character codes and status codes for the c syntax balance checker
package csbc_pkg;

   localparam int COUNT_BITS = 16;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_A       = 8'h61;
   localparam logic [7:0] CH_B       = 8'h62;
   localparam logic [7:0] CH_F       = 8'h66;
   localparam logic [7:0] CH_N       = 8'h6E;
   localparam logic [7:0] CH_R       = 8'h72;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_V       = 8'h76;

   typedef enum logic [5:0] {
      LX_NORMAL  = 6'b000001,
      LX_SLASH   = 6'b000010,
      LX_LINE    = 6'b000100,
      LX_BLOCK   = 6'b001000,
      LX_LITERAL = 6'b010000,
      LX_HALTED  = 6'b100000
   } lexer_state_type;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_BAD_ESCAPE   = 4'd1,
      ST_LIT_NEWLINE  = 4'd2,
      ST_LIT_EOF      = 4'd3,
      ST_NESTED       = 4'd4,
      ST_OPEN_COMMENT = 4'd5,
      ST_BRACES       = 4'd6,
      ST_PARENS       = 4'd7,
      ST_BRACKETS     = 4'd8
   } status_type;

   typedef struct packed {
      lexer_state_type state;
      logic [7:0]      prev;
      logic [7:0]      quote;
   } lex_regs_type;

   typedef struct packed {
      logic inc;
      logic dec;
   } count_op_type;

   typedef struct packed {
      count_op_type brace;
      count_op_type paren;
      count_op_type bracket;
      logic         clear;
   } count_ops_type;

   typedef struct packed {
      logic brace_zero;
      logic paren_zero;
      logic bracket_zero;
   } depth_flags_type;

   typedef struct packed {
      logic       fire;
      status_type status;
      logic [7:0] bad_char;
   } result_type;

endpackage

/* src/c_syntax_balance_checker_core.sv */
// top level of the c syntax balance checker
//
// Takes C source one byte per transfer on the req_ channel (req_mode = 0, byte in
// req_data_byte) and an end-of-file transfer (req_mode = 1). The lexer follows
// plain text, comments and string or character literals and keeps saturating
// counts of braces, parentheses and brackets.
// A result transfer on the rsp_ channel comes at once for a bad escape, a newline
// in a literal or a nested block comment; the checker then ignores bytes until
// end of file. End of file always yields a verdict unless halted, and clears all
// state so the next file starts fresh.
// A result is registered and is on rsp_ in the cycle after the transfer that caused it.
// Throughput: one byte per cycle; the whole lexer step is one level of compares
// and one counter add between the state registers and the result register.
// If the receiver stalls with a result held, req_ready drops until that result
// is taken; the slot frees in the same cycle it is taken.
// Reset: synchronous, active high; lexer in plain text, counts zero, no result.
module c_syntax_balance_checker_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_status,
   output logic [7:0] rsp_bad_char
);
   import csbc_pkg::*;

   lex_regs_type    lex_ff;
   lex_regs_type    lex_in;
   lex_regs_type    lex_nxt;
   count_ops_type   ops;
   depth_flags_type flags;
   result_type      res;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type status_ff;
   status_type status_in;
   logic [7:0] bad_char_ff;
   logic [7:0] bad_char_in;
   logic       req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   csbc_lexer u_lexer (
      .mode      (req_mode),
      .data_byte (req_data_byte),
      .cur       (lex_ff),
      .flags     (flags),
      .nxt       (lex_nxt),
      .ops       (ops),
      .res       (res)
   );

   csbc_depth_counter u_brace (
      .clock (clock),
      .reset (reset),
      .en    (req_xfer),
      .clear (ops.clear),
      .op    (ops.brace),
      .zero  (flags.brace_zero)
   );

   csbc_depth_counter u_paren (
      .clock (clock),
      .reset (reset),
      .en    (req_xfer),
      .clear (ops.clear),
      .op    (ops.paren),
      .zero  (flags.paren_zero)
   );

   csbc_depth_counter u_bracket (
      .clock (clock),
      .reset (reset),
      .en    (req_xfer),
      .clear (ops.clear),
      .op    (ops.bracket),
      .zero  (flags.bracket_zero)
   );

   always_comb begin
      lex_in       = lex_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      bad_char_in  = bad_char_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (req_xfer) begin
         lex_in = lex_nxt;
         if (res.fire) begin
            rsp_valid_in = 1'b1;
            status_in    = res.status;
            bad_char_in  = res.bad_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff.state <= LX_NORMAL;
         lex_ff.prev  <= '0;
         lex_ff.quote <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lex_ff       <= lex_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      bad_char_ff <= bad_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_bad_char = bad_char_ff;

   // the offending byte is only reported with a bad escape
   a_bad_char_only_escape : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_BAD_ESCAPE |-> rsp_bad_char == 8'h00)
      else $error("bad_char set on a status other than bad escape");

   // end of file returns the lexer and all counts to their reset values
   a_eof_clears : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=>
         lex_ff.state == LX_NORMAL && lex_ff.prev == 8'h00 && lex_ff.quote == 8'h00 &&
         flags.brace_zero && flags.paren_zero && flags.bracket_zero)
      else $error("state not cleared after end of file");

   // status codes stay within the defined range
   a_status_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_BRACKETS)
      else $error("status code out of range");

   // a halted lexer produces nothing for source bytes
   a_halted_silent : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode && lex_ff.state == LX_HALTED |=>
         lex_ff.state == LX_HALTED && !($rose(rsp_valid)))
      else $error("halted lexer reacted to a source byte");

endmodule

/* src/csbc_depth_counter.sv */
// saturating signed nesting counter for one bracket kind
module csbc_depth_counter (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   clear,
   input  csbc_pkg::count_op_type op,
   output logic                   zero
);
   import csbc_pkg::*;

   localparam logic [COUNT_BITS-1:0] MAX_DEPTH = {1'b0, {(COUNT_BITS-1){1'b1}}};
   localparam logic [COUNT_BITS-1:0] MIN_DEPTH = {1'b1, {(COUNT_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0] ONE       = {{(COUNT_BITS-1){1'b0}}, 1'b1};

   logic [COUNT_BITS-1:0] depth_ff;
   logic [COUNT_BITS-1:0] depth_in;

   always_comb begin
      depth_in = depth_ff;
      if (en) begin
         if (clear) begin
            depth_in = '0;
         end else if (op.inc && depth_ff != MAX_DEPTH) begin
            depth_in = depth_ff + ONE;
         end else if (op.dec && depth_ff != MIN_DEPTH) begin
            depth_in = depth_ff - ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign zero = (depth_ff == '0);

endmodule

/* src/csbc_lexer.sv */
// one-byte lexer step: next lexer state, counter updates and any result
module csbc_lexer (
   input  logic                      mode,
   input  logic [7:0]                data_byte,
   input  csbc_pkg::lex_regs_type    cur,
   input  csbc_pkg::depth_flags_type flags,
   output csbc_pkg::lex_regs_type    nxt,
   output csbc_pkg::count_ops_type   ops,
   output csbc_pkg::result_type      res
);
   import csbc_pkg::*;

   lex_regs_type  norm_regs;
   count_ops_type norm_ops;
   logic          escape_ok;

   // plain-text handling, also used for the byte after a lone slash
   always_comb begin
      norm_regs       = cur;
      norm_regs.state = LX_NORMAL;
      norm_ops        = '0;
      case (data_byte)
         CH_SLASH: norm_regs.state = LX_SLASH;
         CH_DQUOTE, CH_SQUOTE: begin
            norm_regs.state = LX_LITERAL;
            norm_regs.quote = data_byte;
            norm_regs.prev  = data_byte;
         end
         CH_LBRACE: norm_ops.brace.inc   = 1'b1;
         CH_RBRACE: norm_ops.brace.dec   = 1'b1;
         CH_LPAREN: norm_ops.paren.inc   = 1'b1;
         CH_RPAREN: norm_ops.paren.dec   = 1'b1;
         CH_LBRACK: norm_ops.bracket.inc = 1'b1;
         CH_RBRACK: norm_ops.bracket.dec = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      escape_ok = (data_byte == cur.quote) ||
                  (data_byte inside {CH_A, CH_B, CH_T, CH_N, CH_V, CH_F, CH_R, CH_BSLASH});
   end

   always_comb begin
      nxt          = cur;
      ops          = '0;
      res.fire     = 1'b0;
      res.status   = ST_OK;
      res.bad_char = '0;
      if (mode) begin
         nxt.state = LX_NORMAL;
         nxt.prev  = '0;
         nxt.quote = '0;
         ops.clear = 1'b1;
         if (cur.state != LX_HALTED) begin
            res.fire = 1'b1;
            if (cur.state == LX_LITERAL)  res.status = ST_LIT_EOF;
            else if (cur.state == LX_BLOCK) res.status = ST_OPEN_COMMENT;
            else if (!flags.brace_zero)     res.status = ST_BRACES;
            else if (!flags.paren_zero)     res.status = ST_PARENS;
            else if (!flags.bracket_zero)   res.status = ST_BRACKETS;
         end
      end else begin
         case (cur.state)
            LX_NORMAL: begin
               nxt = norm_regs;
               ops = norm_ops;
            end
            LX_SLASH: begin
               if (data_byte == CH_SLASH) begin
                  nxt.state = LX_LINE;
               end else if (data_byte == CH_STAR) begin
                  nxt.state = LX_BLOCK;
                  nxt.prev  = '0;
               end else begin
                  nxt = norm_regs;
                  ops = norm_ops;
               end
            end
            LX_LINE: begin
               if (data_byte == CH_NEWLINE) nxt.state = LX_NORMAL;
            end
            LX_BLOCK: begin
               if (cur.prev == CH_SLASH && data_byte == CH_STAR) begin
                  nxt.state  = LX_HALTED;
                  res.fire   = 1'b1;
                  res.status = ST_NESTED;
               end else if (cur.prev == CH_STAR && data_byte == CH_SLASH) begin
                  nxt.state = LX_NORMAL;
                  nxt.prev  = '0;
               end else begin
                  nxt.prev = data_byte;
               end
            end
            LX_LITERAL: begin
               if (data_byte == cur.quote && cur.prev != CH_BSLASH) begin
                  nxt.state = LX_NORMAL;
                  nxt.prev  = '0;
               end else if (cur.prev == CH_BSLASH) begin
                  if (escape_ok) begin
                     // an escaped backslash must not escape the next byte
                     nxt.prev = (data_byte == CH_BSLASH) ? 8'h00 : data_byte;
                  end else begin
                     nxt.state    = LX_HALTED;
                     res.fire     = 1'b1;
                     res.status   = ST_BAD_ESCAPE;
                     res.bad_char = data_byte;
                  end
               end else if (data_byte == CH_NEWLINE) begin
                  nxt.state  = LX_HALTED;
                  res.fire   = 1'b1;
                  res.status = ST_LIT_NEWLINE;
               end else begin
                  nxt.prev = data_byte;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

/* sim/tb_top.sv */
// testbench for c_syntax_balance_checker_core: directed and random source files, self-checking
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import csbc_pkg::*;

   localparam int LIMIT_CYCLES  = 2_000_000;
   localparam int DRAIN_LIMIT   = 10_000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct {
      status_type status;
      logic [7:0] bad_char;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_mode;
   logic [7:0] req_data_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [3:0] rsp_status;
   logic [7:0] rsp_bad_char;

   // predicted lexer state
   lexer_state_type                lx_state;
   logic [7:0]                     lx_prev;
   logic [7:0]                     lx_quote;
   logic signed [COUNT_BITS-1:0]   n_brace;
   logic signed [COUNT_BITS-1:0]   n_paren;
   logic signed [COUNT_BITS-1:0]   n_brack;

   verdict_type pending_verdicts[$];

   int   fail_count     = 0;
   int   cycle_count    = 0;
   int   transfers_in   = 0;
   int   files_sent     = 0;
   int   verdicts_seen  = 0;
   int   status_seen[9];
   int   burst_left     = 0;
   bit   sender_gaps    = 1'b0;
   bit   rsp_stalls     = 1'b0;
   logic [7:0] stall_pat = 8'hA5;
   int   stall_tick     = 0;

   logic [7:0] escape_set[8] = '{CH_A, CH_B, CH_T, CH_N, CH_V, CH_F, CH_R, CH_BSLASH};

   c_syntax_balance_checker_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_bad_char  (rsp_bad_char)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stalls follow the bits of stall_pat, which stall_tick steps through and reloads
   always @(posedge clock) begin
      if (stall_tick % 48 == 0)
         stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      rsp_ready <= !rsp_stalls || stall_pat[stall_tick % 8];
      stall_tick++;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected verdict: status %0d bad_char 0x%02h", rsp_status, rsp_bad_char);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_seen++;
            if (want.status <= ST_BRACKETS)
               status_seen[want.status]++;
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_bad_char !== want.bad_char) begin
               $error("bad_char mismatch: expected 0x%02h, actual 0x%02h",
                      want.bad_char, rsp_bad_char);
               fail_count++;
            end
         end
      end
   end

   function automatic void clear_lexer();
      lx_state = LX_NORMAL;
      lx_prev  = 8'h00;
      lx_quote = 8'h00;
      n_brace  = '0;
      n_paren  = '0;
      n_brack  = '0;
   endfunction

   function automatic logic signed [COUNT_BITS-1:0] bumped(
      input logic signed [COUNT_BITS-1:0] cnt, input bit up);
      logic signed [COUNT_BITS-1:0] top;
      logic signed [COUNT_BITS-1:0] bottom;
      top    = {1'b0, {(COUNT_BITS-1){1'b1}}};
      bottom = ~top;
      if (up)
         return (cnt == top) ? cnt : COUNT_BITS'(cnt + 1);
      return (cnt == bottom) ? cnt : COUNT_BITS'(cnt - 1);
   endfunction

   function automatic void plain_char(input logic [7:0] ch);
      case (ch)
         CH_SLASH: lx_state = LX_SLASH;
         CH_DQUOTE, CH_SQUOTE: begin
            lx_state = LX_LITERAL;
            lx_quote = ch;
            lx_prev  = ch;
         end
         CH_LBRACE: n_brace = bumped(n_brace, 1'b1);
         CH_RBRACE: n_brace = bumped(n_brace, 1'b0);
         CH_LPAREN: n_paren = bumped(n_paren, 1'b1);
         CH_RPAREN: n_paren = bumped(n_paren, 1'b0);
         CH_LBRACK: n_brack = bumped(n_brack, 1'b1);
         CH_RBRACK: n_brack = bumped(n_brack, 1'b0);
         default: ;
      endcase
   endfunction

   // advances the predicted lexer by one transfer, returns 1 when a verdict is due
   function automatic bit predict_verdict(input logic mode, input logic [7:0] ch,
                                          output status_type st, output logic [7:0] bad);
      bit fire;
      bit esc_ok;
      fire   = 1'b0;
      esc_ok = (ch == lx_quote);
      st     = ST_OK;
      bad    = 8'h00;
      foreach (escape_set[i])
         if (escape_set[i] == ch)
            esc_ok = 1'b1;
      if (mode) begin
         if (lx_state != LX_HALTED) begin
            fire = 1'b1;
            if (lx_state == LX_LITERAL)
               st = ST_LIT_EOF;
            else if (lx_state == LX_BLOCK)
               st = ST_OPEN_COMMENT;
            else if (n_brace != 0)
               st = ST_BRACES;
            else if (n_paren != 0)
               st = ST_PARENS;
            else if (n_brack != 0)
               st = ST_BRACKETS;
         end
         clear_lexer();
         return fire;
      end
      case (lx_state)
         LX_NORMAL: plain_char(ch);
         LX_SLASH: begin
            if (ch == CH_SLASH) begin
               lx_state = LX_LINE;
            end else if (ch == CH_STAR) begin
               lx_state = LX_BLOCK;
               lx_prev  = 8'h00;
            end else begin
               lx_state = LX_NORMAL;
               plain_char(ch);
            end
         end
         LX_LINE: if (ch == CH_NEWLINE) lx_state = LX_NORMAL;
         LX_BLOCK: begin
            if (lx_prev == CH_SLASH && ch == CH_STAR) begin
               lx_state = LX_HALTED;
               st       = ST_NESTED;
               fire     = 1'b1;
            end else if (lx_prev == CH_STAR && ch == CH_SLASH) begin
               lx_state = LX_NORMAL;
               lx_prev  = 8'h00;
            end else begin
               lx_prev = ch;
            end
         end
         LX_LITERAL: begin
            if (ch == lx_quote && lx_prev != CH_BSLASH) begin
               lx_state = LX_NORMAL;
               lx_prev  = 8'h00;
            end else if (lx_prev == CH_BSLASH) begin
               // an escaped backslash must not escape the next byte
               if (esc_ok) begin
                  lx_prev = (ch == CH_BSLASH) ? 8'h00 : ch;
               end else begin
                  lx_state = LX_HALTED;
                  st       = ST_BAD_ESCAPE;
                  bad      = ch;
                  fire     = 1'b1;
               end
            end else if (ch == CH_NEWLINE) begin
               lx_state = LX_HALTED;
               st       = ST_LIT_NEWLINE;
               fire     = 1'b1;
            end else begin
               lx_prev = ch;
            end
         end
         default: ;
      endcase
      return fire;
   endfunction

   task automatic send_item(input logic mode, input logic [7:0] ch);
      status_type  st;
      logic [7:0]  bad;
      verdict_type v;
      if (sender_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      if (burst_left > 0)
         burst_left--;
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= ch;
      do @(posedge clock); while (!req_ready);
      transfers_in++;
      if (mode)
         files_sent++;
      if (predict_verdict(mode, ch, st, bad)) begin
         v.status   = st;
         v.bad_char = bad;
         pending_verdicts.push_back(v);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(1'b0, s[i]);
   endtask

   task automatic drain_verdicts();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d verdicts never arrived", pending_verdicts.size());
         fail_count++;
         pending_verdicts.delete();
      end
   endtask

   task automatic test_bracket_counts();
      send_text("}(");
      send_item(1'b1, 8'hFF);
      send_text("/(//)\n");
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_text("]");
      send_item(1'b1, 8'h5A);
      drain_verdicts();
   endtask

   task automatic test_literals();
      send_text("'\\\\'");
      send_item(1'b1, 8'h00);
      send_text("\"\\\"\n");
      send_item(1'b1, 8'h00);
      send_text("\"\\");
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'h00);
      send_text("'\\\n");
      send_item(1'b1, 8'h00);
      send_text("'");
      send_item(1'b1, 8'h00);
      drain_verdicts();
   endtask

   task automatic test_comments();
      send_text("/*/");
      send_item(1'b1, 8'h00);
      send_text("/*/*x");
      send_item(1'b1, 8'h00);
      send_text("//x");
      send_item(1'b1, 8'h00);
      drain_verdicts();
   endtask

   // mostly well-formed C-like files with random content, plus some noise
   task automatic test_random_files(input int n_items, input bit gaps, input bit stalls);
      int         target;
      int         ntok;
      int         r;
      int         k;
      logic [7:0] closers[$];
      logic [7:0] q;
      target      = transfers_in + n_items;
      sender_gaps = gaps;
      rsp_stalls  = stalls;
      while (transfers_in < target) begin
         ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 20);
         closers.delete();
         repeat (ntok) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               send_item(1'b0, 8'(CH_A + $urandom_range(0, 25)));
            end else if (r < 40) begin
               k = $urandom_range(0, 2);
               send_item(1'b0, (k == 0) ? CH_LBRACE : (k == 1) ? CH_LPAREN : CH_LBRACK);
               closers.push_back((k == 0) ? CH_RBRACE : (k == 1) ? CH_RPAREN : CH_RBRACK);
            end else if (r < 50) begin
               k = $urandom_range(0, 2);
               if (closers.size() > 0 && $urandom_range(0, 9) != 0)
                  send_item(1'b0, closers.pop_back());
               else
                  send_item(1'b0, (k == 0) ? CH_RBRACE : (k == 1) ? CH_RPAREN : CH_RBRACK);
            end else if (r < 63) begin
               q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
               send_item(1'b0, q);
               repeat ($urandom_range(0, 5)) begin
                  k = $urandom_range(0, 99);
                  if (k < 55) begin
                     send_item(1'b0, 8'(CH_A + $urandom_range(0, 25)));
                  end else if (k < 83) begin
                     send_item(1'b0, CH_BSLASH);
                     k = $urandom_range(0, 8);
                     send_item(1'b0, (k == 8) ? q : escape_set[k]);
                  end else if (k < 92) begin
                     send_item(1'b0, CH_BSLASH);
                     send_item(1'b0, 8'($urandom));
                  end else if (k < 96) begin
                     send_item(1'b0, CH_NEWLINE);
                  end else begin
                     send_item(1'b0, (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
                  end
               end
               if ($urandom_range(0, 29) != 0)
                  send_item(1'b0, q);
            end else if (r < 71) begin
               send_item(1'b0, CH_SLASH);
               send_item(1'b0, CH_SLASH);
               repeat ($urandom_range(0, 6)) send_item(1'b0, 8'($urandom));
               if ($urandom_range(0, 7) != 0)
                  send_item(1'b0, CH_NEWLINE);
            end else if (r < 80) begin
               send_item(1'b0, CH_SLASH);
               send_item(1'b0, CH_STAR);
               repeat ($urandom_range(0, 8)) begin
                  k = $urandom_range(0, 99);
                  if (k < 50)
                     send_item(1'b0, 8'(CH_A + $urandom_range(0, 25)));
                  else if (k < 65)
                     send_item(1'b0, CH_STAR);
                  else if (k < 75)
                     send_item(1'b0, CH_SLASH);
                  else if (k < 85)
                     send_item(1'b0, CH_NEWLINE);
                  else if (k < 95)
                     send_item(1'b0, $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                  else begin
                     send_item(1'b0, CH_SLASH);
                     send_item(1'b0, CH_STAR);
                  end
               end
               if ($urandom_range(0, 14) != 0) begin
                  send_item(1'b0, CH_STAR);
                  send_item(1'b0, CH_SLASH);
               end
            end else if (r < 88) begin
               send_item(1'b0, $urandom_range(0, 1) ? CH_NEWLINE : CH_SPACE);
            end else if (r < 93) begin
               send_item(1'b0, CH_SLASH);
            end else begin
               send_item(1'b0, 8'($urandom));
            end
         end
         if ($urandom_range(0, 3) != 0)
            while (closers.size() > 0)
               send_item(1'b0, closers.pop_back());
         send_item(1'b1, 8'($urandom));
         // now and then hold off until every verdict is back
         if ($urandom_range(0, 11) == 0)
            drain_verdicts();
      end
      drain_verdicts();
   endtask

   initial begin
      foreach (status_seen[i])
         status_seen[i] = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= 1'b0;
      req_data_byte <= 8'h00;
      rsp_ready     <= 1'b0;
      clear_lexer();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      sender_gaps = 1'b1;
      rsp_stalls  = 1'b1;
      test_bracket_counts();
      test_literals();
      test_comments();
      test_random_files(300, 1'b1, 1'b1);
      test_random_files(150, 1'b0, 1'b0);
      test_random_files(150, 1'b1, 1'b1);
      drain_verdicts();

      $display("%0d files, %0d transfers in, %0d verdicts checked, with sender gaps and stalls",
               files_sent, transfers_in, verdicts_seen);
      $display("verdicts by status 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6], status_seen[7],
               status_seen[8]);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
